/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the frame receiver core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CFMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on the edge that follows a reset cycle.
`define CFMR_ASSERT_AFTER_RESET(label, cond, msg) \
  label: assert property (@(posedge clk) rst |=> (cond)) else $error(msg);

`endif

/* design/cfmr_pkg.sv */
// ---------------------------------------------------------------------------
// cfmr_pkg
// Types, constants and the CRC-8 byte update shared by the frame receiver.
// ---------------------------------------------------------------------------
package cfmr_pkg;

  localparam int MAX_BYTES = 32;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [7:0] CMD_REPORT = 8'h45;  // ASCII 'E'

  localparam int CMD_IDX    = 1;
  localparam int DATA_FIRST = 2;
  localparam int DATA_LAST  = 5;
  localparam int LEN_CMD    = 2;
  localparam int LEN_SHORT  = 3;
  localparam int LEN_DATA   = 7;

  typedef enum logic [2:0] {
    ST_SHORT_OK = 3'd0,
    ST_DATA_OK  = 3'd1,
    ST_LEN_ERR  = 3'd2,
    ST_CRC_ERR  = 3'd3,
    ST_REPORT   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    status_t            frame_status;
    logic [CNT_W-1:0]   frame_length;
    logic [7:0]         command_code;
    logic signed [31:0] data_value;
  } result_t;

  // Reflected CRC-8, one whole byte per call, least significant bit first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/cfmr_in_stage.sv */
// ---------------------------------------------------------------------------
// cfmr_in_stage
// Input register: holds one received byte until the frame logic takes it.
// ---------------------------------------------------------------------------
module cfmr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  cfmr_pkg::item_t s_item,
  output logic           q_valid,
  output cfmr_pkg::item_t q_item,
  input  logic           q_take
);
  import cfmr_pkg::*;

  assign s_ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      q_item <= s_item;
    end
  end

endmodule

/* design/cfmr_frame_core.sv */
// ---------------------------------------------------------------------------
// cfmr_frame_core
// Per-frame state: byte count, running CRC, command and data capture, and
// the frame verdict when the closing byte is taken.
// ---------------------------------------------------------------------------
module cfmr_frame_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  cfmr_pkg::item_t  item,
  output logic             item_take,
  input  logic             res_ready,
  output logic             res_valid,
  output cfmr_pkg::result_t res
);
  import cfmr_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next, len;
  logic [7:0]       crc_running, crc_running_next;
  logic [7:0]       crc_before_last, crc_before_last_next;
  logic [7:0]       last_stored_byte, last_stored_byte_next;
  logic [7:0]       pending_command, pending_command_next;
  logic [31:0]      pending_data, pending_data_next;
  logic [7:0]       held_command, held_command_next;
  logic [31:0]      held_data, held_data_next;
  logic             store, crc_ok;
  logic [1:0]       lane;
  status_t          status;

  // A closing byte needs room in the result register; other bytes never wait.
  assign item_take = item_valid && (!item.frame_end || res_ready);
  assign res_valid = item_take && item.frame_end;

  always_comb begin
    store = byte_count < CNT_W'(MAX_BYTES);
    lane  = 2'(byte_count - CNT_W'(DATA_FIRST));

    len                   = byte_count;
    crc_running_next      = crc_running;
    crc_before_last_next  = crc_before_last;
    last_stored_byte_next = last_stored_byte;
    pending_command_next  = pending_command;
    pending_data_next     = pending_data;
    if (store) begin
      len                   = byte_count + CNT_W'(1);
      crc_before_last_next  = crc_running;
      crc_running_next      = crc8_update(crc_running, item.rx_byte);
      last_stored_byte_next = item.rx_byte;
      if (byte_count == CNT_W'(CMD_IDX)) begin
        pending_command_next = item.rx_byte;
      end else if (byte_count >= CNT_W'(DATA_FIRST) && byte_count <= CNT_W'(DATA_LAST)) begin
        pending_data_next[8*lane +: 8] = item.rx_byte;
      end
    end

    crc_ok            = last_stored_byte_next == crc_before_last_next;
    held_command_next = held_command;
    held_data_next    = held_data;
    // On a two-byte frame the check byte is also byte one, so both sources agree.
    if (crc_ok && len >= CNT_W'(LEN_CMD)) begin
      held_command_next = pending_command_next;
    end
    if (crc_ok && len == CNT_W'(LEN_DATA)) begin
      held_data_next = pending_data_next;
    end

    if (!crc_ok) begin
      status = ST_CRC_ERR;
    end else if (held_command_next == CMD_REPORT) begin
      status = ST_REPORT;
    end else if (len == CNT_W'(LEN_SHORT)) begin
      status = ST_SHORT_OK;
    end else if (len == CNT_W'(LEN_DATA)) begin
      status = ST_DATA_OK;
    end else begin
      status = ST_LEN_ERR;
    end

    byte_count_next = len;
    if (item.frame_end) begin
      byte_count_next      = '0;
      crc_running_next     = '0;
      crc_before_last_next = '0;
    end

    res.frame_status = status;
    res.frame_length = len;
    res.command_code = held_command_next;
    res.data_value   = signed'(held_data_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      crc_running      <= '0;
      crc_before_last  <= '0;
      last_stored_byte <= '0;
      pending_command  <= '0;
      pending_data     <= '0;
      held_command     <= '0;
      held_data        <= '0;
    end else if (item_take) begin
      byte_count       <= byte_count_next;
      crc_running      <= crc_running_next;
      crc_before_last  <= crc_before_last_next;
      last_stored_byte <= last_stored_byte_next;
      pending_command  <= pending_command_next;
      pending_data     <= pending_data_next;
      if (item.frame_end) begin
        held_command <= held_command_next;
        held_data    <= held_data_next;
      end
    end
  end

`include "assert_macros.svh"

  `CFMR_ASSERT(a_count_bounded, byte_count <= CNT_W'(MAX_BYTES), "byte count beyond limit")
  `CFMR_ASSERT(a_frame_restart, res_valid |=> (byte_count == '0 && crc_running == '0), "frame state not cleared after frame end")
  `CFMR_ASSERT(a_crc_err_holds, (res_valid && res.frame_status == ST_CRC_ERR) |=> (held_command == $past(held_command) && held_data == $past(held_data)), "held values changed on CRC error")
  `CFMR_ASSERT_AFTER_RESET(a_reset_clear, byte_count == '0 && held_command == '0, "state not cleared by reset")

endmodule

/* design/cfmr_out_stage.sv */
// ---------------------------------------------------------------------------
// cfmr_out_stage
// Result register: holds one frame verdict until the downstream side takes it.
// ---------------------------------------------------------------------------
module cfmr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  cfmr_pkg::result_t res,
  output logic              m_valid,
  input  logic              m_ready,
  output cfmr_pkg::result_t m_res
);
  import cfmr_pkg::*;

  assign res_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (res_ready) begin
      m_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_res <= res;
    end
  end

endmodule

/* design/crc8_framed_message_receiver.sv */
// ---------------------------------------------------------------------------
// crc8_framed_message_receiver
// Path: the closing byte of a frame passes the input register, its verdict
// the result register. Throughput: one byte per cycle while the result side
// keeps up; the CRC-8 byte update is one unrolled step.
// Reset: synchronous, clears the frame state, the held command and data and
// both stages; no clearing pass is needed.
// ---------------------------------------------------------------------------
module crc8_framed_message_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [5:0] frame_length, [13:6] command_code,
                                 // [45:14] data_value, [47:46] zero
  output logic [2:0]  m_tuser    // [2:0] frame_status
);
  import cfmr_pkg::*;

  item_t   s_item, q_item;
  logic    q_valid, q_take;
  logic    res_valid, res_ready;
  result_t res, m_res;

  assign s_item.rx_byte   = s_tdata;
  assign s_item.frame_end = s_tlast;

  cfmr_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  cfmr_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .item_take  (q_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  cfmr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_res     (m_res)
  );

  assign m_tuser = m_res.frame_status;
  assign m_tdata = {2'b00, m_res.data_value, m_res.command_code, m_res.frame_length};

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the CRC-8 framed message receiver
// Bytes are sent as frames with their check byte appended. An in-bench
// predictor works out the verdict that each closing byte should give, and
// every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfmr_pkg::*;

  localparam int STALL_LIMIT = 3000;

  typedef struct {
    status_t          status;
    logic [CNT_W-1:0] length;
    logic [7:0]       command;
    logic [31:0]      data;
  } verdict_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;

  // Predictor state, cleared to match the block after reset.
  logic [CNT_W-1:0] rx_count = '0;
  logic [7:0]       crc_all = '0;
  logic [7:0]       crc_before_check = '0;
  logic [7:0]       newest_byte = '0;
  logic [7:0]       frame_cmd = '0;
  logic [31:0]      frame_data = '0;
  logic [7:0]       held_cmd = '0;
  logic [31:0]      held_data = '0;

  verdict_t pending_verdicts[$];

  int src_idle_pct = 11;
  int sink_idle_pct = 83;
  int bytes_sent = 0;
  int fault_count = 0;
  int verdicts_seen = 0;
  int status_hits[5] = '{default: 0};
  int hold_length = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  crc8_framed_message_receiver i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-8: the byte is folded in first, then shifted out LSB first.
  function automatic logic [7:0] crc_after_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void predict_verdict(logic [7:0] b, logic last);
    verdict_t v;
    if (rx_count < MAX_BYTES) begin
      crc_before_check = crc_all;
      crc_all = crc_after_byte(crc_all, b);
      newest_byte = b;
      if (rx_count == CMD_IDX) begin
        frame_cmd = b;
      end else if (rx_count >= DATA_FIRST && rx_count <= DATA_LAST) begin
        frame_data[8*(rx_count-DATA_FIRST) +: 8] = b;
      end
      rx_count = rx_count + 1'b1;
    end
    if (!last) return;
    v.length = rx_count;
    if (newest_byte != crc_before_check) begin
      v.status = ST_CRC_ERR;
    end else begin
      // In a two-byte frame the check byte itself sits at the command position.
      if (rx_count >= LEN_CMD) held_cmd = (rx_count == LEN_CMD) ? newest_byte : frame_cmd;
      if (rx_count == LEN_DATA) held_data = frame_data;
      if (held_cmd == CMD_REPORT) v.status = ST_REPORT;
      else if (rx_count == LEN_SHORT) v.status = ST_SHORT_OK;
      else if (rx_count == LEN_DATA) v.status = ST_DATA_OK;
      else v.status = ST_LEN_ERR;
    end
    v.command = held_cmd;
    v.data = held_data;
    pending_verdicts.push_back(v);
    rx_count = '0;
    crc_all = '0;
    crc_before_check = '0;
  endfunction

  function automatic void report_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      verdicts_seen++;
      if (m_tuser <= 3'd4) status_hits[m_tuser]++;
      if (pending_verdicts.size() == 0) begin
        report_fault($sformatf("Unexpected verdict: status %0d length %0d cmd %02h data %08h",
                               m_tuser, m_tdata[5:0], m_tdata[13:6], m_tdata[45:14]));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tuser != want.status || m_tdata[5:0] != want.length ||
            m_tdata[13:6] != want.command || m_tdata[45:14] != want.data) begin
          report_fault($sformatf(
            "Mismatch: expected %s len %0d cmd %02h data %08h, got %0d len %0d cmd %02h data %08h",
            want.status.name(), want.length, want.command, want.data,
            m_tuser, m_tdata[5:0], m_tdata[13:6], m_tdata[45:14]));
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      m_tready <= 1'b0;
      hold_left <= hold_length - 1;
      hold_served <= hold_ticket;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_verdict(b, last);
    bytes_sent++;
  endtask

  // Appends the check byte to the body; dropped bytes follow beyond the limit.
  task automatic send_frame_bytes(input byte_q_t body, input bit bad_crc, input int dropped);
    logic [7:0] check;
    check = '0;
    foreach (body[i]) check = crc_after_byte(check, body[i]);
    if (bad_crc) check ^= 8'($urandom_range(1, 255));
    foreach (body[i]) send_byte(body[i], 1'b0);
    send_byte(check, dropped == 0);
    for (int i = 1; i <= dropped; i++) send_byte(8'($urandom_range(255)), i == dropped);
  endtask

  task automatic wait_for_verdicts();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic send_random_frame();
    byte_q_t body;
    int pick;
    int stored;
    int dropped;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // Stray byte, possibly breaking up the next frame.
      send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      return;
    end
    dropped = 0;
    if (pick < 40) begin
      stored = LEN_SHORT;
    end else if (pick < 72) begin
      stored = LEN_DATA;
    end else if (pick < 96) begin
      stored = $urandom_range(1, MAX_BYTES);
    end else begin
      stored = MAX_BYTES;
      dropped = $urandom_range(1, 5);
    end
    for (int i = 0; i < stored - 1; i++) body.push_back(8'($urandom_range(255)));
    if (stored > LEN_CMD && $urandom_range(99) < 15) body[CMD_IDX] = CMD_REPORT;
    send_frame_bytes(body, $urandom_range(99) < 15, dropped);
  endtask

  task automatic test_accepted_lengths();
    send_frame_bytes('{8'h00, 8'hFF}, 1'b0, 0);
    send_frame_bytes('{8'hA5, 8'h31, 8'h00, 8'h00, 8'h00, 8'h80}, 1'b0, 0);
    wait_for_verdicts();
  endtask

  task automatic test_rejected_frames();
    send_frame_bytes('{8'h12, 8'h34, 8'h56}, 1'b0, 0);
    send_frame_bytes('{8'hFF, 8'h01}, 1'b1, 0);
    wait_for_verdicts();
  endtask

  task automatic test_error_report();
    send_frame_bytes('{8'h7E, CMD_REPORT}, 1'b0, 0);
    wait_for_verdicts();
  endtask

  // A lone zero byte matches the CRC of nothing; the report command is still held.
  task automatic test_tiny_frames();
    send_byte(8'h00, 1'b1);
    send_frame_bytes('{8'hC3}, 1'b0, 0);
    send_byte(8'h00, 1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_overlong_frames();
    byte_q_t body;
    for (int i = 0; i < MAX_BYTES - 1; i++) body.push_back(8'($urandom_range(255)));
    send_frame_bytes(body, 1'b0, 0);
    send_frame_bytes(body, 1'b0, 3);
    send_frame_bytes(body, 1'b1, 1);
    wait_for_verdicts();
  endtask

  // The result side is held off while short frames keep coming, so the block
  // has to stall its input.
  task automatic test_backpressure();
    byte_q_t body;
    hold_length = 300;
    hold_ticket++;
    repeat (40) begin
      body = '{8'($urandom_range(255)), 8'($urandom_range(255))};
      send_frame_bytes(body, 1'b0, 0);
    end
    wait_for_verdicts();
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_frame();
    wait_for_verdicts();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_accepted_lengths();
    test_rejected_frames();
    test_error_report();
    test_tiny_frames();
    test_overlong_frames();
    test_random_traffic(510);

    src_idle_pct = 83;
    sink_idle_pct = 11;
    test_random_traffic(510);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_random_traffic(560);

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes and checked %0d frame verdicts under three idling mixes.",
             bytes_sent, verdicts_seen);
    $display("Verdicts: short %0d, data %0d, length %0d, crc %0d, report %0d; faults %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], fault_count);
    if (pending_verdicts.size() != 0) begin
      $display("%0d predicted verdicts never arrived", pending_verdicts.size());
    end
    if (fault_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
